FILE: design/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

    // Fixed field widths of the streaming payload.
    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 6;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;
    localparam int KIND_W      = 2;
    localparam int ENTRY_W     = 2 * DATA_W;

    // Default table depth.
    localparam int DEF_MAX_POINTS = 64;

    // Configuration register map.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int COUNT_W    = 7;
    localparam logic [APB_ADDR_W-1:0] ADDR_POINT_COUNT = 3'd0;
    localparam logic [COUNT_W-1:0]    POINT_COUNT_RESET = 7'd1;

    // Request command codes carried on tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result kinds carried on tuser.
    localparam logic [KIND_W-1:0] KIND_LOAD_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INTERP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLAMP_LOW  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLAMP_HIGH = 2'd3;

    // Number of quotient bits produced by the divider.
    localparam int DIV_STEPS = 32;

    // One breakpoint as it sits in the table: ordinate above abscissa.
    typedef struct packed {
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] x;
    } entry_t;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: design/pli_table.sv
`timescale 1ns / 1ps

module pli_table
    import pli_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_POINTS,
    parameter int ADDR_W = $clog2(DEF_MAX_POINTS)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    // Breakpoint storage with one write port and one registered read port.
    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/pli_div.sv
`timescale 1ns / 1ps

module pli_div
    import pli_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ENTRY_W-1:0]  dividend,
    input  logic [DATA_W-1:0]   divisor,
    output div_status_t         status,
    output logic [DATA_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // that the upper half of the dividend is below the divisor, so the
    // quotient fits in DATA_W bits.
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] shift_reg, shift_next;
    logic [DATA_W-1:0] dvsr_reg, dvsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        dvsr_next  = dvsr_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, shift_reg[DATA_W-1]} - {1'b0, dvsr_reg};

        if (start)
        begin
            rem_next   = dividend[ENTRY_W-1:DATA_W];
            shift_next = dividend[DATA_W-1:0];
            dvsr_next  = divisor;
            step_next  = STEP_W'(DIV_STEPS - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DATA_W])
            begin
                rem_next   = {rem_reg[DATA_W-2:0], shift_reg[DATA_W-1]};
                shift_next = {shift_reg[DATA_W-2:0], 1'b0};
            end
            else
            begin
                rem_next   = trial[DATA_W-1:0];
                shift_next = {shift_reg[DATA_W-2:0], 1'b1};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        dvsr_reg  <= dvsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = shift_reg;

endmodule

FILE: design/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps

// Piecewise linear interpolation table over signed Q16.16 breakpoints. A
// request with tuser = 0 loads one breakpoint (x, y) into the given slot and
// is answered with a load acknowledgement of value zero; slots beyond
// MAX_POINTS are not written but still acknowledged. A request with tuser = 1
// queries abscissa x: at or below the first breakpoint the first y is
// returned as clamped low, at or above the last breakpoint in use the last y
// is returned as clamped high, and otherwise the first interval with
// x[i] <= q < x[i+1] is found and y0 + (y1 - y0) * (q - x0) / (x1 - x0) is
// returned, the division truncating toward zero. Breakpoints must be loaded
// in ascending x order and every slot in use must be written before a query
// reads it. The number of breakpoints in use is set through the point_count
// register at address 0 (values below one act as one, values above
// MAX_POINTS as MAX_POINTS); write it only while the block is idle. A load
// goes from idle through the output state. A query reads the first and then
// the last breakpoint and checks the clamps, then scans the table through its
// single read port one breakpoint after another, and an interpolated answer
// adds a multiply step, a restoring divider and a step to pick up the
// quotient before the output state, which waits while the output register
// still holds an untaken result. The block takes no new request while a query
// or load is in progress, but it does take one while its last result still
// waits in the output register.

module piecewise_linear_interpolator
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [5:0] point_index, [37:6] x_value, [69:38] y_value, [71:70] zero.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] cmd.
    input  logic                   s_tuser,

    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] result_value.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [1:0] result_kind.
    output logic [KIND_W-1:0]      m_tuser,

    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RDL   = 4'd2;
    localparam logic [3:0] S_CLAMP = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_TEST  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [COUNT_W-1:0]      point_count_reg;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic signed [DATA_W-1:0] q_reg, q_next;
    entry_t                  first_reg, first_next;
    entry_t                  prev_reg, prev_next;
    logic [DATA_W-1:0]       dx_reg, dx_next;
    logic [DATA_W-1:0]       dq_reg, dq_next;
    logic [DATA_W-1:0]       dy_mag_reg, dy_mag_next;
    logic                    neg_reg, neg_next;
    logic [DATA_W-1:0]       y0_reg, y0_next;
    logic [ENTRY_W-1:0]      prod_reg, prod_next;
    logic [DATA_W-1:0]       res_value_reg, res_value_next;
    logic [KIND_W-1:0]       res_kind_reg, res_kind_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [KIND_W-1:0]       m_tuser_reg, m_tuser_next;

    logic [WIDE_W-1:0]       cnt_wide;
    logic [WIDE_W-1:0]       n_eff;
    logic [IDX_W-1:0]        last_idx;
    logic                    accept;
    logic                    cfg_write;
    logic                    tbl_wr_en;
    logic                    tbl_rd_en;
    logic [IDX_W-1:0]        tbl_rd_addr;
    entry_t                  tbl_wr_data;
    entry_t                  tbl_rd_data;
    logic                    div_start;
    div_status_t             div_stat;
    logic [DATA_W-1:0]       div_quo;
    logic [DATA_W:0]         dy_wide;
    logic [DATA_W-1:0]       x_in;
    logic [DATA_W-1:0]       y_in;
    logic [INDEX_W-1:0]      idx_in;

    // Payload fields of the request.
    assign idx_in = s_tdata[INDEX_W-1:0];
    assign x_in   = s_tdata[INDEX_W+DATA_W-1:INDEX_W];
    assign y_in   = s_tdata[INDEX_W+2*DATA_W-1:INDEX_W+DATA_W];

    // Configuration register. Writes complete in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RESET;
        end
        else if (cfg_write && paddr == ADDR_POINT_COUNT)
        begin
            point_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_POINT_COUNT) ? APB_DATA_W'(point_count_reg) : '0;

    // Effective breakpoint count, saturated into one to MAX_POINTS.
    always_comb
    begin
        cnt_wide = WIDE_W'(point_count_reg);
        if (cnt_wide == '0)
        begin
            n_eff = WIDE_W'(1);
        end
        else if (cnt_wide > WIDE_W'(MAX_POINTS))
        begin
            n_eff = WIDE_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = cnt_wide;
        end
    end

    assign last_idx = IDX_W'(n_eff - WIDE_W'(1));

    // A request is taken only when the sequencer is idle.
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Loads write the table in the cycle they are accepted.
    assign tbl_wr_en     = accept && s_tuser == CMD_LOAD
                           && 32'(idx_in) < 32'(MAX_POINTS);
    assign tbl_wr_data.x = x_in;
    assign tbl_wr_data.y = y_in;

    // Read port is driven by the sequencer state.
    always_comb
    begin
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = '0;
        unique case (state_reg)
            S_RD0:
            begin
                tbl_rd_en = 1'b1;
            end
            S_RDL:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = last_idx;
            end
            S_SCAN:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = scan_idx_reg;
            end
            default:
            begin
                tbl_rd_en = 1'b0;
            end
        endcase
    end

    pli_table #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (IDX_W'(idx_in)),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    assign div_start = (state_reg == S_MUL);

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_next),
        .divisor  (dx_reg),
        .status   (div_stat),
        .quotient (div_quo)
    );

    // Ordinate difference of the bracketing breakpoints, one bit wider.
    assign dy_wide = {tbl_rd_data.y[DATA_W-1], tbl_rd_data.y}
                     - {prev_reg.y[DATA_W-1], prev_reg.y};

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        q_next         = q_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        dx_next        = dx_reg;
        dq_next        = dq_reg;
        dy_mag_next    = dy_mag_reg;
        neg_next       = neg_reg;
        y0_next        = y0_reg;
        prod_next      = prod_reg;
        res_value_next = res_value_reg;
        res_kind_next  = res_kind_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_LOAD)
                    begin
                        res_value_next = '0;
                        res_kind_next  = KIND_LOAD_ACK;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        q_next     = $signed(x_in);
                        state_next = S_RD0;
                    end
                end
            end
            S_RD0:
            begin
                state_next = S_RDL;
            end
            S_RDL:
            begin
                // The first breakpoint arrives while the last one is read.
                first_next = tbl_rd_data;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (q_reg <= $signed(first_reg.x))
                begin
                    res_value_next = first_reg.y;
                    res_kind_next  = KIND_CLAMP_LOW;
                    state_next     = S_OUT;
                end
                else if (q_reg >= $signed(tbl_rd_data.x))
                begin
                    res_value_next = tbl_rd_data.y;
                    res_kind_next  = KIND_CLAMP_HIGH;
                    state_next     = S_OUT;
                end
                else
                begin
                    prev_next     = first_reg;
                    scan_idx_next = IDX_W'(1);
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if ($signed(prev_reg.x) <= q_reg && q_reg < $signed(tbl_rd_data.x))
                begin
                    // Widths are positive and offsets nonnegative, both below 2^32 here.
                    dx_next     = tbl_rd_data.x - prev_reg.x;
                    dq_next     = q_reg - prev_reg.x;
                    neg_next    = dy_wide[DATA_W];
                    dy_mag_next = dy_wide[DATA_W] ? DATA_W'(-dy_wide)
                                                  : dy_wide[DATA_W-1:0];
                    y0_next     = prev_reg.y;
                    state_next  = S_MUL;
                end
                else if (scan_idx_reg == last_idx)
                begin
                    // No bracketing interval; an ascending table never gets here.
                    res_value_next = first_reg.y;
                    res_kind_next  = KIND_INTERP;
                    state_next     = S_OUT;
                end
                else
                begin
                    prev_next     = tbl_rd_data;
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    state_next    = S_SCAN;
                end
            end
            S_MUL:
            begin
                // The product feeds the divider as it is registered.
                prod_next  = ENTRY_W'(dy_mag_reg) * ENTRY_W'(dq_reg);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    res_value_next = neg_reg ? (y0_reg - div_quo) : (y0_reg + div_quo);
                    res_kind_next  = KIND_INTERP;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_value_reg;
                    m_tuser_next  = res_kind_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        first_reg     <= first_next;
        prev_reg      <= prev_next;
        dx_reg        <= dx_next;
        dq_reg        <= dq_next;
        dy_mag_reg    <= dy_mag_next;
        neg_reg       <= neg_next;
        y0_reg        <= y0_next;
        prod_reg      <= prod_next;
        res_value_reg <= res_value_next;
        res_kind_reg  <= res_kind_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The table is only written by a load taken in the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr_en |-> state_reg == S_IDLE)
        else $error("table written outside the idle state");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // The scan never leaves the breakpoints in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_TEST)
        |-> (scan_idx_reg != '0 && scan_idx_reg <= last_idx))
        else $error("scan index out of range");

    // A load acknowledgement always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_LOAD_ACK) |-> m_tdata == '0)
        else $error("load acknowledgement with nonzero value");

endmodule

FILE: verif/piecewise_linear_interpolator_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the interpolation table. Load and query requests are
// queued by the stimulus process and sent by a clocked driver. The monitor
// predicts the answer to every request accepted on the bus and compares each
// result with the oldest prediction still waiting.
module piecewise_linear_interpolator_tb;
    import pli_pkg::*;

    localparam int TABLE_DEPTH    = DEF_MAX_POINTS;
    localparam int ITEM_TARGET    = 1120;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic                  cmd;
        logic [INDEX_W-1:0]    point_index;
        logic [DATA_W-1:0]     x_value;
        logic [DATA_W-1:0]     y_value;
    } request_t;

    typedef struct {
        logic [DATA_W-1:0]     value;
        logic [KIND_W-1:0]     kind;
    } answer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Requests waiting for the driver and answers waiting for the monitor.
    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       outstanding = 0;
    int       item_count = 0;
    int       error_count = 0;
    int       quiet_cycles = 0;
    int       sender_idle_pct = 12;
    int       receiver_idle_pct = 46;

    // Predicted contents of the block.
    logic [DATA_W-1:0]  bp_x[TABLE_DEPTH];
    logic [DATA_W-1:0]  bp_y[TABLE_DEPTH];
    logic [COUNT_W-1:0] point_count_seen = POINT_COUNT_RESET;

    // What the stimulus has loaded so far, used to aim the queries.
    logic [DATA_W-1:0]  staged_x[TABLE_DEPTH];

    piecewise_linear_interpolator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    function automatic longint sx(logic [DATA_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint rand_below(longint unsigned n);
        longint unsigned r;
        r = {$urandom, $urandom};
        return longint'(r % n);
    endfunction

    // Applies one request to the predicted table and returns its answer.
    function automatic answer_t interpolate_request(request_t req);
        answer_t     ans;
        int          n;
        int          i;
        longint      q;
        longint      xl;
        longint      xh;
        longint      yl;
        longint      dy;
        logic [63:0] mag;
        logic [63:0] quo;
        ans.value = '0;
        ans.kind  = KIND_LOAD_ACK;
        if (req.cmd == CMD_LOAD) begin
            bp_x[req.point_index] = req.x_value;
            bp_y[req.point_index] = req.y_value;
            return ans;
        end
        n = (point_count_seen == 0) ? 1 :
            (point_count_seen > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count_seen);
        q = sx(req.x_value);
        if (q <= sx(bp_x[0])) begin
            ans.value = bp_y[0];
            ans.kind  = KIND_CLAMP_LOW;
        end else if (q >= sx(bp_x[n-1])) begin
            ans.value = bp_y[n-1];
            ans.kind  = KIND_CLAMP_HIGH;
        end else begin
            ans.value = bp_y[0];
            ans.kind  = KIND_INTERP;
            // The first interval that holds q wins, even in an unordered table.
            for (i = 0; i + 1 < n; i++) begin
                xl = sx(bp_x[i]);
                xh = sx(bp_x[i+1]);
                if (xl <= q && q < xh) begin
                    yl  = sx(bp_y[i]);
                    dy  = sx(bp_y[i+1]) - yl;
                    mag = 64'(dy < 0 ? -dy : dy) * 64'(q - xl);
                    quo = mag / 64'(xh - xl);
                    ans.value = 32'(dy < 0 ? yl - longint'(quo) : yl + longint'(quo));
                    break;
                end
            end
        end
        return ans;
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    // Request driver: a new request is presented once the current one is taken.
    always @(posedge clk) begin
        request_t req;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, req.y_value, req.x_value, req.point_index};
                s_tuser  <= req.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        m_tready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: checks results, predicts accepted requests, tracks the register.
    always @(posedge clk) begin
        request_t taken;
        answer_t  want;
        if (!rst_n) begin
            point_count_seen = POINT_COUNT_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    flag_error($sformatf("result %h kind %0d with no request waiting",
                                         m_tdata, m_tuser));
                end else begin
                    want = expected_answers.pop_front();
                    outstanding--;
                    if (m_tdata !== want.value || m_tuser !== want.kind)
                        flag_error($sformatf("expected value %h kind %0d, got value %h kind %0d",
                                             want.value, want.kind, m_tdata, m_tuser));
                end
            end
            if (s_tvalid && s_tready) begin
                taken.cmd         = s_tuser;
                taken.point_index = s_tdata[INDEX_W-1:0];
                taken.x_value     = s_tdata[INDEX_W +: DATA_W];
                taken.y_value     = s_tdata[INDEX_W+DATA_W +: DATA_W];
                expected_answers.push_back(interpolate_request(taken));
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_POINT_COUNT)
                point_count_seen = pwdata[COUNT_W-1:0];
        end
    end

    // Watchdog: too long without any transfer on either stream means a hang.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_load(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] x,
                             input logic [DATA_W-1:0] y);
        request_t req;
        req.cmd         = CMD_LOAD;
        req.point_index = idx;
        req.x_value     = x;
        req.y_value     = y;
        staged_x[idx]   = x;
        pending_requests.push_back(req);
        outstanding++;
        item_count++;
    endtask

    // The slot and ordinate fields of a query are ignored, so they carry noise.
    task automatic push_query(input logic [DATA_W-1:0] q);
        request_t req;
        req.cmd         = CMD_QUERY;
        req.point_index = INDEX_W'($urandom);
        req.x_value     = q;
        req.y_value     = $urandom;
        pending_requests.push_back(req);
        outstanding++;
        item_count++;
    endtask

    task automatic drain();
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // The register is only written once every request has been answered.
    task automatic write_point_count(input int value);
        drain();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POINT_COUNT;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_ordinate();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly inside the loaded span, often on or next to a breakpoint.
    function automatic logic [DATA_W-1:0] pick_abscissa(int points);
        longint lo;
        longint hi;
        int     r;
        lo = sx(staged_x[0]);
        hi = sx(staged_x[points-1]);
        r  = $urandom_range(99);
        if (r < 60 && hi > lo)
            return 32'(lo + rand_below(longint'(hi - lo + 1)));
        if (r < 75)
            return staged_x[$urandom_range(points - 1)] + 32'($urandom_range(2)) - 32'd1;
        if (r < 85) begin
            case ($urandom_range(3))
                0:       return staged_x[0];
                1:       return staged_x[points-1];
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // One phase: set the count, load a table, then query it with a little noise.
    task automatic random_round(input int round_no);
        int     cfg;
        int     pick;
        int     points;
        int     shape;
        int     queries;
        int     i;
        longint limit;
        longint step_max;
        longint offset;
        longint base;
        longint offs[TABLE_DEPTH];
        case (round_no)
            0: cfg = 127;
            1: cfg = 64;
            2: cfg = 1;
            default: begin
                pick = $urandom_range(99);
                if (pick < 70)      cfg = $urandom_range(2, 8);
                else if (pick < 85) cfg = $urandom_range(9, 63);
                else if (pick < 90) cfg = 64;
                else if (pick < 95) cfg = $urandom_range(0, 1);
                else                cfg = $urandom_range(65, 127);
            end
        endcase
        write_point_count(cfg);
        points = (cfg == 0) ? 1 : (cfg > TABLE_DEPTH) ? TABLE_DEPTH : cfg;

        // Ascending tables with random spacing; some with repeated x, a few unordered.
        shape = $urandom_range(99);
        limit = 64'hFFFF_FFFF / points;
        case ($urandom_range(3))
            0:       step_max = 4;
            1:       step_max = 64'h0001_0000;
            default: step_max = limit;
        endcase
        if (step_max > limit)
            step_max = limit;
        offset = 0;
        for (i = 0; i < points; i++) begin
            if (i > 0)
                offset += (shape >= 80 && $urandom_range(3) == 0) ? 0 : 1 + rand_below(step_max);
            offs[i] = offset;
        end
        base = -64'sh8000_0000 + rand_below(64'hFFFF_FFFF - offset + 1);
        for (i = 0; i < points; i++)
            push_load(INDEX_W'(i), (shape >= 92) ? $urandom : 32'(base + offs[i]),
                      pick_ordinate());

        queries = $urandom_range(4, 24);
        for (i = 0; i < queries; i++) begin
            // Stray loads land anywhere, sometimes breaking the order in use.
            if ($urandom_range(99) < 6)
                push_load(INDEX_W'($urandom), $urandom, pick_ordinate());
            push_query(pick_abscissa(points));
        end
    endtask

    initial begin
        int round_no;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // After reset a single breakpoint is in use: below, on and above it.
        push_load(0, 32'h0000_0000, 32'h0064_0000);
        push_query(32'h8000_0000);
        push_query(32'h0000_0000);
        push_query(32'h0000_0001);
        // A count of zero acts as one.
        write_point_count(0);
        push_query(32'h7FFF_FFFF);

        // Full-range table: steepest slopes and both clamps at the extremes.
        write_point_count(4);
        push_load(0, 32'h8000_0000, 32'h7FFF_FFFF);
        push_load(1, 32'h0000_0000, 32'h8000_0000);
        push_load(2, 32'h0000_0001, 32'h0000_0000);
        push_load(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_query(32'h8000_0000);
        push_query(32'hFFFF_FFFF);
        push_query(32'h0000_0000);
        push_query(32'h0000_0001);
        push_query(32'h7FFF_FFFE);
        push_query(32'h7FFF_FFFF);

        // Two breakpoints share one x, so the empty interval is skipped.
        write_point_count(3);
        push_load(0, 32'h000A_0000, 32'hFFFB_0000);
        push_load(1, 32'h000A_0000, 32'h0007_0000);
        push_load(2, 32'h0014_0000, 32'h0064_0000);
        push_query(32'h000F_0000);
        push_query(32'h000A_0000);
        // The highest slot, outside the part of the table in use.
        push_load(63, 32'hFFFF_FFFF, 32'h5555_AAAA);

        round_no = 0;
        while (item_count < ITEM_TARGET) begin
            if (item_count < 450) begin
                sender_idle_pct   = 12;
                receiver_idle_pct = 46;
            end else if (item_count < 850) begin
                sender_idle_pct   = 46;
                receiver_idle_pct = 12;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            random_round(round_no);
            round_no++;
        end

        drain();
        repeat (200) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
